FILE: hdl/pmed_pkg.sv
// ----------------------------------------------------------------------------
// pmed_pkg: shared types and constants for the presence and motion detector
// Holds the item layouts, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package pmed_pkg;

  // Distance kept in millimetres (raw quarter-mm sample shifted right by two)
  localparam int unsigned DistW   = 13;
  localparam int unsigned RawW    = 15;
  localparam int unsigned StatusW = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DistW-1:0] StartMin     = 13'd3500;
  localparam logic [DistW-1:0] PrevMinReset = 13'd400;

  localparam logic [ThrW-1:0]  DistThrReset    = 16'd400;
  localparam logic [WordW-1:0] MotionThrReset  = 32'd3000000;
  localparam logic [WordW-1:0] NearPeriodReset = 32'd10000;
  localparam logic [WordW-1:0] ImmobileToReset = 32'd2000;

  typedef enum logic [1:0] {
    EV_REPORT = 2'd0,
    EV_NEAR   = 2'd1,
    EV_MOTION = 2'd2,
    EV_STILL  = 2'd3
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIST_THR    = 2'd0,
    CFG_MOTION_THR  = 2'd1,
    CFG_NEAR_PERIOD = 2'd2,
    CFG_IMMOBILE_TO = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RawW-1:0]    zone_distance_raw;
    logic [StatusW-1:0] zone_status;
    logic [WordW-1:0]   zone_motion;
    logic               frame_end;
    logic [WordW-1:0]   time_now;
  } in_item_t;

  typedef struct packed {
    event_kind_e      event_kind;
    logic [DistW-1:0] frame_min_distance;
    logic [WordW-1:0] frame_max_motion;
    logic             last_of_run;
  } out_item_t;

  // One finished frame waiting to be sent as a run of results
  typedef struct packed {
    logic [DistW-1:0] min_dist;
    logic [WordW-1:0] max_motion;
    logic             near;
    logic             ms_valid;
    event_kind_e      ms_kind;
  } frame_rec_t;

endpackage

FILE: hdl/pmed_in_if.sv
// ----------------------------------------------------------------------------
// pmed_in_if: zone sample channel
// Valid/ready channel that carries one zone sample per transaction.
// ----------------------------------------------------------------------------
interface pmed_in_if;
  logic               valid;
  logic               ready;
  pmed_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pmed_out_if.sv
// ----------------------------------------------------------------------------
// pmed_out_if: event result channel
// Valid/ready channel that carries one frame report or event per transaction.
// ----------------------------------------------------------------------------
interface pmed_out_if;
  logic                valid;
  logic                ready;
  pmed_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/presence_motion_event_detector.sv
// ----------------------------------------------------------------------------
// presence_motion_event_detector: per-frame presence and motion events
// Folds zone samples into a frame minimum distance and maximum motion and
// turns each frame end into a report plus optional near/motion/still events.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one zone sample per transaction. Samples are folded into
//          the running minimum distance and maximum motion in the cycle they
//          are accepted, so one sample can be taken every cycle.
//   out_o  carries the results. A sample with frame_end set yields a run of
//          one to three results: frame report, then near, then motion
//          started or still. last_of_run marks the final one of the run.
//   cfg_*  writes a threshold register; write only while idle.
// Output: a frame end sample's record is registered into the record queue
//   when accepted; a run moves one result per cycle while out_o.ready holds.
// Throughput: one sample per cycle. Finished frames wait in a two-entry
//   record queue; in_i.ready drops only while both entries are occupied,
//   i.e. when the receiver stalls or frames end closer than their runs drain.
// Reset: thresholds return to their defaults, running values restart, the
//   block is immobile and the record queue is empty.
// ----------------------------------------------------------------------------
module presence_motion_event_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pmed_in_if.sink                          in_i,
  pmed_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [pmed_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pmed_pkg::WordW-1:0]       cfg_wdata_i
);
  import pmed_pkg::*;

  typedef enum logic [2:0] {
    PH_REPORT = 3'b001,
    PH_NEAR   = 3'b010,
    PH_MS     = 3'b100
  } phase_e;

  // Configuration registers
  logic [ThrW-1:0]  dist_thr_q;
  logic [WordW-1:0] motion_thr_q;
  logic [WordW-1:0] near_period_q;
  logic [WordW-1:0] immobile_to_q;

  // Frame tracking state
  logic [DistW-1:0] run_min_q, run_min_d;
  logic [WordW-1:0] run_max_q, run_max_d;
  logic [DistW-1:0] prev_min_q, prev_min_d;
  logic [WordW-1:0] last_near_q, last_near_d;
  logic [WordW-1:0] last_motion_q, last_motion_d;
  logic             still_q, still_d;

  // Record queue and output sequencing
  frame_rec_t rec_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  phase_e     phase_q, phase_d;

  logic [DistW-1:0] dist_mm;
  logic [DistW-1:0] cur_min;
  logic [WordW-1:0] cur_max;
  logic             in_fire, push, out_fire, pop;
  logic             near_hit, motion_hit, start_hit, still_hit;
  frame_rec_t       new_rec;
  frame_rec_t       head;
  event_kind_e      out_kind;
  logic             out_last;

  // Accept while a queue slot is free
  assign in_i.ready = (count_q != 2'd2);
  assign in_fire    = in_i.valid & in_i.ready;
  assign push       = in_fire & in_i.data.frame_end;

  // Fold the current zone into the running values
  always_comb begin
    dist_mm = in_i.data.zone_distance_raw[RawW-1:2];
    cur_min = ((|in_i.data.zone_status) && (dist_mm < run_min_q)) ? dist_mm : run_min_q;
    cur_max = (in_i.data.zone_motion > run_max_q) ? in_i.data.zone_motion : run_max_q;
  end

  // Frame end decisions; timestamp differences wrap modulo 2^32
  always_comb begin
    near_hit   = ({3'b000, cur_min} <= dist_thr_q)
              && ({3'b000, prev_min_q} > dist_thr_q)
              && ((in_i.data.time_now - last_near_q) >= near_period_q);
    motion_hit = (cur_max >= motion_thr_q);
    start_hit  = motion_hit && still_q;
    still_hit  = !motion_hit && !still_q
              && ((in_i.data.time_now - last_motion_q) > immobile_to_q);

    new_rec.min_dist   = cur_min;
    new_rec.max_motion = cur_max;
    new_rec.near       = near_hit;
    new_rec.ms_valid   = start_hit | still_hit;
    new_rec.ms_kind    = start_hit ? EV_MOTION : EV_STILL;
  end

  // Next state of the tracking registers
  always_comb begin
    run_min_d     = run_min_q;
    run_max_d     = run_max_q;
    prev_min_d    = prev_min_q;
    last_near_d   = last_near_q;
    last_motion_d = last_motion_q;
    still_d       = still_q;
    if (in_fire) begin
      if (in_i.data.frame_end) begin
        // Restart the running values for the next frame
        run_min_d  = StartMin;
        run_max_d  = '0;
        prev_min_d = cur_min;
        if (near_hit) begin
          last_near_d = in_i.data.time_now;
        end
        if (motion_hit) begin
          last_motion_d = in_i.data.time_now;
        end
        if (start_hit) begin
          still_d = 1'b0;
        end else if (still_hit) begin
          still_d = 1'b1;
        end
      end else begin
        run_min_d = cur_min;
        run_max_d = cur_max;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q     <= StartMin;
      run_max_q     <= '0;
      prev_min_q    <= PrevMinReset;
      last_near_q   <= '0;
      last_motion_q <= '0;
      still_q       <= 1'b1;
    end else begin
      run_min_q     <= run_min_d;
      run_max_q     <= run_max_d;
      prev_min_q    <= prev_min_d;
      last_near_q   <= last_near_d;
      last_motion_q <= last_motion_d;
      still_q       <= still_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_thr_q    <= DistThrReset;
      motion_thr_q  <= MotionThrReset;
      near_period_q <= NearPeriodReset;
      immobile_to_q <= ImmobileToReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DIST_THR:    dist_thr_q    <= cfg_wdata_i[ThrW-1:0];
        CFG_MOTION_THR:  motion_thr_q  <= cfg_wdata_i;
        CFG_NEAR_PERIOD: near_period_q <= cfg_wdata_i;
        CFG_IMMOBILE_TO: immobile_to_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Present the head record as a run of results
  assign head = rec_q[rd_ptr_q];

  always_comb begin
    unique case (phase_q)
      PH_REPORT: begin
        out_kind = EV_REPORT;
        out_last = !head.near && !head.ms_valid;
      end
      PH_NEAR: begin
        out_kind = EV_NEAR;
        out_last = !head.ms_valid;
      end
      PH_MS: begin
        out_kind = head.ms_kind;
        out_last = 1'b1;
      end
      default: begin
        out_kind = EV_REPORT;
        out_last = 1'b1;
      end
    endcase
  end

  assign out_o.valid                   = (count_q != 2'd0);
  assign out_o.data.event_kind         = out_kind;
  assign out_o.data.frame_min_distance = head.min_dist;
  assign out_o.data.frame_max_motion   = head.max_motion;
  assign out_o.data.last_of_run        = out_last;

  assign out_fire = out_o.valid & out_o.ready;
  assign pop      = out_fire & out_last;

  // Advance through the run; drop the record after its last result
  always_comb begin
    phase_d = phase_q;
    if (out_fire) begin
      if (out_last) begin
        phase_d = PH_REPORT;
      end else if ((phase_q == PH_REPORT) && head.near) begin
        phase_d = PH_NEAR;
      end else begin
        phase_d = PH_MS;
      end
    end
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      phase_q  <= PH_REPORT;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Record storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      rec_q[wr_ptr_q] <= new_rec;
    end
  end

endmodule

FILE: hdl/pmed_checker.sv
// ----------------------------------------------------------------------------
// pmed_checker: port-level checks for the presence and motion detector
// Watches the result channel for run structure and stall behavior.
// ----------------------------------------------------------------------------
module pmed_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input pmed_pkg::out_item_t           out_data_i
);
  import pmed_pkg::*;

  logic out_fire;
  logic prev_last_q;

  assign out_fire = out_valid_i & out_ready_i;

  // Track whether the previous result closed its run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
    end else if (out_fire) begin
      prev_last_q <= out_data_i.last_of_run;
    end
  end

  // A run opens with the frame report
  a_run_opens_with_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_last_q |-> out_data_i.event_kind == EV_REPORT)
    else $error("run did not open with a frame report");

  // Events only follow inside an open run
  a_event_inside_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_i.event_kind != EV_REPORT |-> !prev_last_q)
    else $error("event outside a frame run");

  // Motion and still events always close the run
  a_ms_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.event_kind == EV_MOTION || out_data_i.event_kind == EV_STILL)
    |-> out_data_i.last_of_run)
    else $error("motion or still event not last of run");

  // Frame minimum never exceeds the start value
  a_min_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.frame_min_distance <= StartMin)
    else $error("frame minimum above start value");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

endmodule

bind presence_motion_event_detector pmed_checker u_pmed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
